### hdl/complete_rank_transform_window_core_assert.svh
// Assertion helpers shared by the rank transform RTL.
// Each macro expects clk and rst_n in scope.
`ifndef COMPLETE_RANK_TRANSFORM_WINDOW_CORE_ASSERT_SVH
`define COMPLETE_RANK_TRANSFORM_WINDOW_CORE_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define CRTW_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/crtw_pkg.sv
`default_nettype none
package crtw_pkg;

  // field widths
  localparam int PIX_W        = 8;
  localparam int RANK_W       = 5;
  localparam int IDX_W        = 5;
  localparam int CCOL_W       = 11;
  localparam int CROW_W       = 16;
  localparam int OUT_FIELDS_W = RANK_W + IDX_W + CCOL_W + CROW_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // config port
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd2048;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1080;

  // parameter defaults
  localparam int DEF_WINDOW    = 5;
  localparam int DEF_MAX_WIDTH = 2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // sequencer -> window store controls
  typedef struct packed {
    logic rd;     // read line store column
    logic shift;  // write back shifted column, shift window
  } win_ctl_t;

endpackage
`default_nettype wire

### hdl/crtw_window.sv
`default_nettype none
module crtw_window #(
  parameter int WINDOW    = crtw_pkg::DEF_WINDOW,
  parameter int MAX_WIDTH = crtw_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire crtw_pkg::win_ctl_t                            ctl,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]                  addr,
  input  wire logic [crtw_pkg::PIX_W-1:0]                    pixel,
  output logic      [WINDOW*WINDOW*crtw_pkg::PIX_W-1:0]      win_flat
);
  import crtw_pkg::*;

  localparam int LsW = (WINDOW - 1) * PIX_W;

  // one word per column: line k in bits [8k+7:8k], oldest line lowest
  logic [LsW-1:0]   mem [MAX_WIDTH];
  logic [LsW-1:0]   rd_data_r;
  logic [PIX_W-1:0] win_r   [WINDOW][WINDOW];
  logic [PIX_W-1:0] col_in  [WINDOW];

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data_r <= mem[addr];
    end
    if (ctl.shift) begin
      mem[addr] <= {pixel, rd_data_r[LsW-1:PIX_W]};
    end
  end

  always_comb begin
    for (int dy = 0; dy < WINDOW - 1; dy++) begin
      col_in[dy] = rd_data_r[dy*PIX_W +: PIX_W];
    end
    col_in[WINDOW-1] = pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int dy = 0; dy < WINDOW; dy++) begin
        for (int dx = 0; dx < WINDOW; dx++) begin
          win_r[dy][dx] <= '0;
        end
      end
    end else if (ctl.shift) begin
      for (int dy = 0; dy < WINDOW; dy++) begin
        for (int dx = 0; dx < WINDOW - 1; dx++) begin
          win_r[dy][dx] <= win_r[dy][dx+1];
        end
        win_r[dy][WINDOW-1] <= col_in[dy];
      end
    end
  end

  always_comb begin
    for (int dy = 0; dy < WINDOW; dy++) begin
      for (int dx = 0; dx < WINDOW; dx++) begin
        win_flat[(dy*WINDOW+dx)*PIX_W +: PIX_W] = win_r[dy][dx];
      end
    end
  end

endmodule
`default_nettype wire

### hdl/crtw_rank_unit.sv
`default_nettype none
module crtw_rank_unit #(
  parameter int WINDOW = crtw_pkg::DEF_WINDOW
) (
  input  wire logic [WINDOW*WINDOW*crtw_pkg::PIX_W-1:0] win_flat,
  input  wire logic [$clog2(WINDOW*WINDOW)-1:0]         sel,
  output logic      [$clog2(WINDOW*WINDOW)-1:0]         rank
);
  import crtw_pkg::*;

  localparam int Area    = WINDOW * WINDOW;
  localparam int RowCntW = $clog2(WINDOW + 1);
  localparam int RankW   = $clog2(Area);

  logic [PIX_W-1:0]   pivot;
  logic [RowCntW-1:0] row_cnt [WINDOW];

  assign pivot = win_flat[sel*PIX_W +: PIX_W];

  // strict less-than leaves the pivot itself out; count per row, then sum rows
  always_comb begin
    for (int dy = 0; dy < WINDOW; dy++) begin
      row_cnt[dy] = '0;
      for (int dx = 0; dx < WINDOW; dx++) begin
        row_cnt[dy] = row_cnt[dy]
                    + RowCntW'(win_flat[(dy*WINDOW+dx)*PIX_W +: PIX_W] < pivot);
      end
    end
    rank = '0;
    for (int dy = 0; dy < WINDOW; dy++) begin
      rank = rank + RankW'(row_cnt[dy]);
    end
  end

endmodule
`default_nettype wire

### hdl/complete_rank_transform_window_core.sv
// Complete rank transform: takes 8-bit grey pixels in raster order and, for
// every pixel whose WINDOW x WINDOW neighborhood lies inside the configured
// image, emits WINDOW*WINDOW words, one per window element in row-major order,
// each carrying the count of window elements strictly smaller than it, the
// element index and the window center; tlast marks the final word of a pixel.
// Border pixels produce no output. Each pixel is accepted with a line-store
// read, then shifted into the window; an interior pixel then has its window
// elements ranked in order by the single rank unit, which ranks one window
// element per cycle; output back-pressure can stall that.
// The output register lets the next pixel be accepted while the last word
// waits. The line store is a single-port column memory of MAX_WIDTH words,
// not cleared after reset. Width and height changes take effect at once and
// should be made between images; the raster position is not cleared.
`default_nettype none
`include "complete_rank_transform_window_core_assert.svh"
module complete_rank_transform_window_core #(
  parameter int WINDOW    = crtw_pkg::DEF_WINDOW,
  parameter int MAX_WIDTH = crtw_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // config
  input  wire logic                               cfg_we,
  input  wire logic [crtw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [crtw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // pixel stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [crtw_pkg::PIX_W-1:0]         in_tdata,   // [7:0] pixel
  // rank stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [4:0] rank, [9:5] element_index, [20:10] center_column,
  // [36:21] center_row, [39:37] zero
  output logic [crtw_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                    out_tlast   // last_of_pixel
);
  import crtw_pkg::*;

  localparam int Area = WINDOW * WINDOW;
  localparam int Half = WINDOW / 2;
  localparam int IdxW = $clog2(Area);
  localparam int ColW = $clog2(MAX_WIDTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Area - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RANK
  } state_t;

  // config registers
  logic [WIDTH_REG_W-1:0]  image_width_r;
  logic [HEIGHT_REG_W-1:0] image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp width to [1, MAX_WIDTH], height to at least 1
  logic [ColW:0]         width_use;
  logic [HEIGHT_REG_W:0] height_use;

  always_comb begin
    if (image_width_r == '0) begin
      width_use = (ColW+1)'(1);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      width_use = (ColW+1)'(MAX_WIDTH);
    end else begin
      width_use = (ColW+1)'(image_width_r);
    end
    if (image_height_r == '0) begin
      height_use = (HEIGHT_REG_W+1)'(1);
    end else begin
      height_use = {1'b0, image_height_r};
    end
  end

  // sequencer state
  state_t              state_r,     state_nxt;
  logic [ColW-1:0]     col_r,       col_nxt;
  logic [CROW_W-1:0]   row_r,       row_nxt;
  logic [PIX_W-1:0]    pix_r,       pix_nxt;
  logic [IdxW-1:0]     idx_r,       idx_nxt;
  logic [CCOL_W-1:0]   ccol_r,      ccol_nxt;
  logic [CROW_W-1:0]   crow_r,      crow_nxt;
  // output register
  logic                out_vld_r,   out_vld_nxt;
  logic [IdxW-1:0]     out_rank_r,  out_rank_nxt;
  logic [IdxW-1:0]     out_idx_r,   out_idx_nxt;
  logic [CCOL_W-1:0]   out_ccol_r,  out_ccol_nxt;
  logic [CROW_W-1:0]   out_crow_r,  out_crow_nxt;
  logic                out_last_r,  out_last_nxt;

  win_ctl_t                      win_ctl;
  logic [Area*PIX_W-1:0]         win_flat;
  logic [IdxW-1:0]               rank;
  logic                          issue;
  logic                          interior;
  logic [ColW:0]                 col_inc;
  logic [HEIGHT_REG_W:0]         row_inc;

  assign in_tready   = (state_r == ST_IDLE);
  assign win_ctl.rd    = (state_r == ST_IDLE) && in_tvalid;
  assign win_ctl.shift = (state_r == ST_LOAD);

  crtw_window #(
    .WINDOW    (WINDOW),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (win_ctl),
    .addr     (col_r),
    .pixel    (pix_r),
    .win_flat (win_flat)
  );

  crtw_rank_unit #(
    .WINDOW (WINDOW)
  ) u_rank (
    .win_flat (win_flat),
    .sel      (idx_r),
    .rank     (rank)
  );

  assign issue    = (state_r == ST_RANK) && (!out_vld_r || out_tready);
  assign interior = (32'(col_r) >= 32'(WINDOW - 1)) && (32'(row_r) >= 32'(WINDOW - 1));
  assign col_inc  = {1'b0, col_r} + (ColW+1)'(1);
  assign row_inc  = {1'b0, row_r} + (HEIGHT_REG_W+1)'(1);

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    pix_nxt      = pix_r;
    idx_nxt      = idx_r;
    ccol_nxt     = ccol_r;
    crow_nxt     = crow_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_rank_nxt = out_rank_r;
    out_idx_nxt  = out_idx_r;
    out_ccol_nxt = out_ccol_r;
    out_crow_nxt = out_crow_r;
    out_last_nxt = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          pix_nxt   = in_tdata;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // window shifts this cycle; latch center, step raster position
        ccol_nxt = CCOL_W'(col_r - ColW'(Half));
        crow_nxt = row_r - CROW_W'(Half);
        idx_nxt  = '0;
        if (col_inc >= width_use) begin
          col_nxt = '0;
          if (row_inc >= height_use) begin
            row_nxt = '0;
          end else begin
            row_nxt = row_inc[CROW_W-1:0];
          end
        end else begin
          col_nxt = col_inc[ColW-1:0];
        end
        state_nxt = interior ? ST_RANK : ST_IDLE;
      end
      ST_RANK: begin
        if (issue) begin
          out_vld_nxt  = 1'b1;
          out_rank_nxt = rank;
          out_idx_nxt  = idx_r;
          out_ccol_nxt = ccol_r;
          out_crow_nxt = crow_r;
          out_last_nxt = (idx_r == LastIdx);
          if (idx_r == LastIdx) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IdxW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      col_r      <= '0;
      row_r      <= '0;
      idx_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      idx_r      <= idx_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    pix_r      <= pix_nxt;
    ccol_r     <= ccol_nxt;
    crow_r     <= crow_nxt;
    out_rank_r <= out_rank_nxt;
    out_idx_r  <= out_idx_nxt;
    out_ccol_r <= out_ccol_nxt;
    out_crow_r <= out_crow_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_crow_r, out_ccol_r,
                       IDX_W'(out_idx_r), RANK_W'(out_rank_r)};

  // element counter never runs past the window
  `CRTW_ASSERT(a_idx_range, (state_r != ST_RANK) || (idx_r <= LastIdx), "element index overrun")
  // a rank can never reach the window area
  `CRTW_ASSERT(a_rank_range, !out_vld_r || (out_rank_r <= LastIdx), "rank out of range")
  // tlast only on the final element of the window
  `CRTW_ASSERT(a_last_idx, !out_vld_r || (out_last_r == (out_idx_r == LastIdx)), "tlast misplaced")
  // issuing the final element returns the sequencer to idle
  `CRTW_ASSERT_NEXT(a_last_idle, issue && (idx_r == LastIdx), state_r == ST_IDLE, "no idle after last")

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import crtw_pkg::*;

  localparam int WIN  = DEF_WINDOW;
  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int AREA = WIN * WIN;
  localparam int HALF = WIN / 2;

  // cycles to wait after the last rank word before touching a register:
  // a border pixel gives no word but still holds the core through accept
  // and window shift, an interior one through its ranking as well
  localparam int DRAIN_SLACK = 2 * AREA + 10;
  // long back-pressure burst; the core must fill up and drop in_tready
  localparam int HOLD_CYCLES = 600;
  localparam int KEEP_REG    = -1;

  // one rank word, laid out like {tlast, tdata} so a plain cast unpacks it
  typedef struct packed {
    logic              last;
    logic [CROW_W-1:0] crow;
    logic [CCOL_W-1:0] ccol;
    logic [IDX_W-1:0]  idx;
    logic [RANK_W-1:0] rank;
  } rank_word_t;

  typedef enum logic [2:0] {
    PAT_FLAT_LOW, PAT_FLAT_HIGH, PAT_RAMP_UP, PAT_RAMP_DOWN,
    PAT_CHECKER, PAT_NOISE, PAT_FEW_LEVELS, PAT_TWO_LEVEL
  } pixel_pat_e;

  // how the ranks of an image are known: from the predictor, none at all, or typed in
  typedef enum logic [2:0] {
    EXP_PREDICTED, EXP_NONE, EXP_FLAT, EXP_ASCENDING, EXP_DESCENDING
  } expect_mode_e;

  // one image: register values (KEEP_REG = leave as is), content, size
  typedef struct packed {
    int           w_cfg;
    int           h_cfg;
    pixel_pat_e   pat;
    int unsigned  pixels;
    expect_mode_e mode;
  } image_job_t;

  // Directed images. The 5x5 ones have a single interior pixel whose window
  // is the whole image in raster order, so flat and ramp contents give ranks
  // that can be typed straight in; the ramp-up one puts junk in the unused
  // upper width bits. Width and height below the window and zero width and
  // height (taken as 1) follow. The last two rows open a 65535-row image and
  // cut the height to 5 at raster row 6: that row runs out, then wraps.
  localparam int N_DIRECTED = 11;
  image_job_t directed_jobs [N_DIRECTED] = '{
    '{5,        5,        PAT_FLAT_LOW,   25, EXP_FLAT},
    '{KEEP_REG, KEEP_REG, PAT_FLAT_HIGH,  25, EXP_FLAT},
    '{61445,    KEEP_REG, PAT_RAMP_UP,    25, EXP_ASCENDING},
    '{KEEP_REG, KEEP_REG, PAT_RAMP_DOWN,  25, EXP_DESCENDING},
    '{KEEP_REG, KEEP_REG, PAT_CHECKER,    25, EXP_PREDICTED},
    '{4,        5,        PAT_NOISE,      20, EXP_NONE},
    '{5,        4,        PAT_NOISE,      20, EXP_NONE},
    '{0,        5,        PAT_NOISE,       5, EXP_NONE},
    '{5,        0,        PAT_NOISE,       5, EXP_NONE},
    '{6,        65535,    PAT_FEW_LEVELS, 36, EXP_PREDICTED},
    '{KEEP_REG, 5,        PAT_NOISE,       6, EXP_PREDICTED}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  cfg_reg_t              cfg_index  = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tlast;

  complete_rank_transform_window_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: own copy of line store, window, raster position and
  // the two registers.
  // ---------------------------------------------------------------------
  bit   [PIX_W-1:0]        line_mem [WIN-1][MAXW];
  bit   [PIX_W-1:0]        win_regs [AREA];
  int unsigned             col_pos    = 0;
  int unsigned             row_pos    = 0;
  logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;

  rank_word_t  pending_ranks [$];   // rank words still owed by the core
  int unsigned rank_errors   = 0;

  // idle odds (percent) for each side, and the back-pressure burst request
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  // Shift one pixel into the window and queue the ranks it produces.
  task automatic rank_transform_step(input logic [PIX_W-1:0] pix, input bit keep);
    logic [PIX_W-1:0] fresh [WIN];
    int unsigned col, rnk, w_used, h_used;
    rank_word_t word;
    col = col_pos % MAXW;
    // new window column: line store top to bottom, then the incoming pixel
    for (int k = 0; k < WIN - 1; k++) fresh[k] = line_mem[k][col];
    fresh[WIN-1] = pix;
    for (int k = 0; k < WIN - 1; k++) line_mem[k][col] = fresh[k+1];
    for (int dy = 0; dy < WIN; dy++) begin
      for (int dx = 0; dx < WIN - 1; dx++)
        win_regs[dy*WIN + dx] = win_regs[dy*WIN + dx + 1];
      win_regs[dy*WIN + WIN - 1] = fresh[dy];
    end
    if (keep && col >= WIN - 1 && row_pos >= WIN - 1) begin
      for (int i = 0; i < AREA; i++) begin
        rnk = 0;
        for (int j = 0; j < AREA; j++)
          if (j != i && win_regs[j] < win_regs[i]) rnk++;
        word.rank = RANK_W'(rnk);
        word.idx  = IDX_W'(i);
        word.ccol = CCOL_W'(col - HALF);
        word.crow = CROW_W'(row_pos - HALF);
        word.last = (i == AREA - 1);
        pending_ranks.push_back(word);
      end
    end
    // raster advance; zero width/height count as 1, width clamps to MAXW
    w_used = (width_reg == 0) ? 1 : (width_reg > MAXW) ? MAXW : width_reg;
    h_used = (height_reg == 0) ? 1 : height_reg;
    if (col_pos + 1 >= w_used) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h_used) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  // Register write; the extra edge keeps back-to-back writes from raising
  // and lowering cfg_we in the same step.
  task automatic write_reg(input cfg_reg_t which, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (which == REG_IMAGE_WIDTH) width_reg = WIDTH_REG_W'(value);
    else                          height_reg = HEIGHT_REG_W'(value);
  endtask

  // Stop offering pixels, wait for every owed word, then let the core settle.
  task automatic drain_ranks();
    in_tvalid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic run_image(input image_job_t job);
    int unsigned k, gap, rnk;
    logic [PIX_W-1:0] pix;
    rank_word_t word;
    // registers only change with the core idle
    if (job.w_cfg != KEEP_REG || job.h_cfg != KEEP_REG) drain_ranks();
    if (job.w_cfg != KEEP_REG) write_reg(REG_IMAGE_WIDTH, job.w_cfg);
    if (job.h_cfg != KEEP_REG) write_reg(REG_IMAGE_HEIGHT, job.h_cfg);
    // typed-in ranks of the single 5x5 interior pixel, centered at (2,2)
    if (job.mode == EXP_FLAT || job.mode == EXP_ASCENDING ||
        job.mode == EXP_DESCENDING) begin
      for (int i = 0; i < AREA; i++) begin
        case (job.mode)
          EXP_FLAT:      rnk = 0;
          EXP_ASCENDING: rnk = i;
          default:       rnk = AREA - 1 - i;
        endcase
        word.rank = RANK_W'(rnk);
        word.idx  = IDX_W'(i);
        word.ccol = CCOL_W'(HALF);
        word.crow = CROW_W'(HALF);
        word.last = (i == AREA - 1);
        pending_ranks.push_back(word);
      end
    end
    for (k = 0; k < job.pixels; k++) begin
      case (job.pat)
        PAT_FLAT_LOW:   pix = '0;
        PAT_FLAT_HIGH:  pix = '1;
        PAT_RAMP_UP:    pix = PIX_W'(10 * k);
        PAT_RAMP_DOWN:  pix = PIX_W'(255 - 10 * k);
        PAT_CHECKER:    pix = k[0] ? '1 : '0;
        PAT_FEW_LEVELS: pix = PIX_W'($urandom_range(0, 3));     // many ties
        PAT_TWO_LEVEL:  pix = $urandom_range(0, 1) ? '1 : '0;
        default:        pix = PIX_W'($urandom_range(0, 255));
      endcase
      // random gap before the word; valid stays high across back-to-back words
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= pix;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      rank_transform_step(pix, job.mode == EXP_PREDICTED);
    end
  endtask

  // ---------------------------------------------------------------------
  // Rank word checker and out_tready driver. Values are sampled at the
  // edge, before any update of that edge lands.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : rank_checker
    rank_word_t seen, want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = rank_word_t'({out_tlast, out_tdata[OUT_FIELDS_W-1:0]});
      if (pending_ranks.size() == 0) begin
        $error("rank word %h with nothing outstanding", seen);
        rank_errors++;
      end else begin
        want = pending_ranks.pop_front();
        if (seen.rank != want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, seen.rank);
          rank_errors++;
        end
        if (seen.idx != want.idx) begin
          $error("element_index: expected %0d, got %0d", want.idx, seen.idx);
          rank_errors++;
        end
        if (seen.ccol != want.ccol) begin
          $error("center_column: expected %0d, got %0d", want.ccol, seen.ccol);
          rank_errors++;
        end
        if (seen.crow != want.crow) begin
          $error("center_row: expected %0d, got %0d", want.crow, seen.crow);
          rank_errors++;
        end
        if (seen.last != want.last) begin
          $error("last_of_pixel: expected %0d, got %0d", want.last, seen.last);
          rank_errors++;
        end
      end
    end
    // long hold-off on request, otherwise random idling
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      out_tready <= 1'b0;
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: three idling phases (receiver-heavy stalls / sender-heavy
  // gaps swapped in / none); directed images first, then one random small
  // image per phase, and a short run at the clamped maximum width at the end.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    image_job_t job;
    int unsigned w, h;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 35; recv_idle_pct <= 66; end
        1: begin send_idle_pct = 66; recv_idle_pct <= 35; end
        default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
      endcase
      if (phase == 0)
        for (int n = 0; n < N_DIRECTED; n++) run_image(directed_jobs[n]);
      // sink stops for a long while as the sender keeps offering
      if (phase == 1) hold_req <= hold_req + 1;
      w = $urandom_range(WIN, 7);
      h = $urandom_range(WIN, 6);
      case ($urandom_range(0, 3))
        0, 1:    job.pat = PAT_NOISE;
        2:       job.pat = PAT_FEW_LEVELS;
        default: job.pat = PAT_TWO_LEVEL;
      endcase
      job.w_cfg  = w;
      job.h_cfg  = h;
      job.pixels = w * h;
      job.mode   = EXP_PREDICTED;
      run_image(job);
    end

    // width register all ones clamps to MAXW; a few border pixels only
    job = '{4095, WIN, PAT_NOISE, WIN, EXP_PREDICTED};
    run_image(job);

    drain_ranks();
    if (rank_errors == 0) begin
      $display("** complete_rank_transform_window_core: PASSED **");
    end else begin
      $display("** complete_rank_transform_window_core: FAILED **");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #(6_000_000);
    $display("** complete_rank_transform_window_core: FAILED **");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/crtw_pkg.sv
hdl/crtw_window.sv
hdl/crtw_rank_unit.sv
hdl/complete_rank_transform_window_core.sv
verif/testbench.sv
